### design/c8_pkg.sv
package c8_pkg;

    localparam int MEM_BYTES   = 4096;
    localparam int MEM_AW      = 12;
    localparam int SCR_W       = 64;
    localparam int SCR_H       = 32;
    localparam int ROW_AW      = 5;
    localparam int DEF_STACK   = 16;
    localparam int FONT_BYTES  = 80;
    localparam logic [11:0] PC_START = 12'h200;

    typedef enum logic [1:0] {
        OP_EXEC  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2
    } item_op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_WAITKEY = 2'd1,
        ST_UNKNOWN = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ALU_PASS = 3'd0,
        ALU_OR   = 3'd1,
        ALU_AND  = 3'd2,
        ALU_XOR  = 3'd3,
        ALU_ADD  = 3'd4,
        ALU_SUB  = 3'd5,
        ALU_SHR  = 3'd6,
        ALU_SHL  = 3'd7
    } alu_op_t;

    localparam logic [7:0] FONT_ROM [0:FONT_BYTES-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
        logic [7:0] b;
        b = 8'h00;
        if (a < 12'(FONT_BYTES)) begin
            b = FONT_ROM[a[6:0]];
        end
        return b;
    endfunction

endpackage

### design/chip8_instruction_core.sv
// CHIP-8 interpreter core. Each input item executes one instruction (tuser 0),
// writes one memory byte (tuser 1) or reads one 64-pixel framebuffer row
// (tuser 2), and gives exactly one result item. After reset the core loads the
// font and zeroes memory, one byte per cycle, with s_tready low. An execute
// item reads the two opcode bytes one at a time out of the single-port main
// memory, then VX and VY out of the register file, then makes one pass
// through the shared 8-bit ALU. Block instructions walk memory through that
// same port: DXYN reads and then draws each sprite row, FX65 reads and then
// loads each register, FX55 stores each register, FX33 writes three decimal
// digits. Memory and read items skip the fetch. One item is worked on at a
// time; the result register lets a new item in while the last result waits.
module chip8_instruction_core
    import c8_pkg::*;
#(
    parameter int STACK_DEPTH = DEF_STACK
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // address[11:0], write_byte[19:12], keys_down[35:20], key_event_valid[36],
    // key_event_code[40:37], random_byte[48:41]
    input  logic [55:0] s_tdata,
    // op[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // program_counter[11:0], sound_on[12], screen_changed[13], row_pixels[77:14]
    output logic [79:0] m_tdata,
    // status[1:0]
    output logic [1:0]  m_tuser
);
    localparam int SPW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [12:0] {
        S_IDLE     = 13'h0001,
        S_FETCH_HI = 13'h0002,
        S_FETCH_LO = 13'h0004,
        S_READ_X   = 13'h0008,
        S_READ_Y   = 13'h0010,
        S_EXEC     = 13'h0020,
        S_DRAW_RD  = 13'h0040,
        S_DRAW_WR  = 13'h0080,
        S_STORE    = 13'h0100,
        S_LOAD_RD  = 13'h0200,
        S_LOAD_WR  = 13'h0400,
        S_BCD      = 13'h0800,
        S_DONE     = 13'h1000
    } state_t;

    state_t state_reg, state_next;

    // architectural state
    logic [7:0]  v_reg [16];
    logic [7:0]  v_next [16];
    logic [11:0] stack_reg [STACK_DEPTH];
    logic [11:0] stack_next [STACK_DEPTH];
    logic [SPW-1:0] sp_reg, sp_next;
    logic [15:0] i_reg, i_next;
    logic [11:0] pc_reg, pc_next;
    logic [7:0]  dt_reg, dt_next, st_reg, st_next;
    logic        pk_valid_reg, pk_valid_next;
    logic [3:0]  pk_code_reg, pk_code_next;
    logic [SCR_W-1:0] fb_reg [SCR_H];
    logic [SCR_W-1:0] fb_next [SCR_H];
    logic [SCR_H-1:0] fb_ok_reg, fb_ok_next;   // row drawn since reset or last 00E0

    // item working registers
    logic [15:0] keys_reg, keys_next;
    logic [7:0]  rnd_reg, rnd_next;
    logic [1:0]  op_reg, op_next;
    logic [15:0] ins_reg, ins_next;
    logic [7:0]  vx_reg, vx_next, vy_reg, vy_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic        flag_reg, flag_next;
    status_t     status_reg, status_next;
    logic        chg_reg, chg_next;
    logic [63:0] row_reg, row_next;

    // memory clear after reset
    logic        clr_reg;
    logic [11:0] clr_cnt_reg;

    // output register
    logic        m_valid_reg;
    logic [79:0] m_data_reg;
    logic [1:0]  m_user_reg;

    // memory port
    logic        mem_we;
    logic [11:0] mem_addr;
    logic [7:0]  mem_wdata, mem_rdata;

    // ALU
    alu_op_t     alu_sel;
    logic [7:0]  alu_a, alu_b, alu_y;
    logic        alu_flag;

    logic        s_acc;
    logic        out_free;
    logic [3:0]  xi, yi, nib;
    logic [7:0]  nn;
    logic [11:0] nnn, pc2, pc4, ioff;
    logic [SPW-1:0] sp_inc, sp_dec;
    logic [7:0]  dt_dec, st_dec;
    logic [8:0]  draw_row;
    logic [63:0] draw_bits, draw_old;
    logic [7:0]  bcd_h, bcd_t, bcd_o;

    c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_mem (
        .clk   (aclk),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    c8_alu u_alu (
        .sel  (alu_sel),
        .a    (alu_a),
        .b    (alu_b),
        .y    (alu_y),
        .flag (alu_flag)
    );

    function automatic logic known_op(input logic [15:0] w);
        logic k;
        k = 1'b1;
        unique case (w[15:12])
            4'h0: k = (w == 16'h00E0) || (w == 16'h00EE);
            4'h8: k = (w[3:0] <= 4'h7) || (w[3:0] == 4'hE);
            4'hE: k = (w[7:0] == 8'h9E) || (w[7:0] == 8'hA1);
            4'hF: k = (w[7:0] == 8'h07) || (w[7:0] == 8'h0A) || (w[7:0] == 8'h15) ||
                      (w[7:0] == 8'h18) || (w[7:0] == 8'h1E) || (w[7:0] == 8'h29) ||
                      (w[7:0] == 8'h33) || (w[7:0] == 8'h55) || (w[7:0] == 8'h65);
            default: k = 1'b1;
        endcase
        return k;
    endfunction

    assign s_tready = (state_reg == S_IDLE) && !clr_reg;
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;

    assign xi  = ins_reg[11:8];
    assign yi  = ins_reg[7:4];
    assign nib = ins_reg[3:0];
    assign nn  = ins_reg[7:0];
    assign nnn = ins_reg[11:0];
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;
    assign ioff = i_reg[11:0] + {8'd0, cnt_reg};

    assign sp_inc = (sp_reg == SPW'(STACK_DEPTH - 1)) ? '0 : sp_reg + 1'b1;
    assign sp_dec = (sp_reg == '0) ? SPW'(STACK_DEPTH - 1) : sp_reg - 1'b1;
    assign dt_dec = (dt_reg != 8'd0) ? dt_reg - 8'd1 : 8'd0;
    assign st_dec = (st_reg != 8'd0) ? st_reg - 8'd1 : 8'd0;

    // sprite row
    assign draw_row  = {1'b0, vy_reg} + {5'd0, cnt_reg};
    assign draw_bits = {mem_rdata, 56'd0} >> vx_reg[5:0];
    assign draw_old  = fb_ok_reg[draw_row[4:0]] ? fb_reg[draw_row[4:0]] : 64'd0;

    // decimal digits of VX
    always_comb begin
        logic [7:0] r;
        bcd_h = (vx_reg >= 8'd200) ? 8'd2 : (vx_reg >= 8'd100) ? 8'd1 : 8'd0;
        r = vx_reg - ((bcd_h << 6) + (bcd_h << 5) + (bcd_h << 2));
        bcd_t = 8'd0;
        for (int k = 1; k < 10; k++) begin
            if (r >= 8'(k * 10)) begin
                bcd_t = 8'(k);
            end
        end
        bcd_o = r - ((bcd_t << 3) + (bcd_t << 1));
    end

    // ALU operand selection
    always_comb begin
        alu_sel = ALU_PASS;
        alu_a   = vx_reg;
        alu_b   = vy_reg;
        case (ins_reg[15:12])
            4'h7: begin
                alu_sel = ALU_ADD;
                alu_b   = nn;
            end
            4'hC: begin
                alu_sel = ALU_AND;
                alu_a   = rnd_reg;
                alu_b   = nn;
            end
            default: begin
                case (nib)
                    4'h0: alu_sel = ALU_PASS;
                    4'h1: alu_sel = ALU_OR;
                    4'h2: alu_sel = ALU_AND;
                    4'h3: alu_sel = ALU_XOR;
                    4'h4: alu_sel = ALU_ADD;
                    4'h5: alu_sel = ALU_SUB;
                    4'h6: alu_sel = ALU_SHR;
                    4'h7: begin
                        alu_sel = ALU_SUB;
                        alu_a   = vy_reg;
                        alu_b   = vx_reg;
                    end
                    default: alu_sel = ALU_SHL;
                endcase
            end
        endcase
    end

    // memory port
    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = ioff;
        mem_wdata = v_reg[cnt_reg];
        if (clr_reg) begin
            mem_we    = 1'b1;
            mem_addr  = clr_cnt_reg;
            mem_wdata = font_byte(clr_cnt_reg);
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    mem_addr  = s_tdata[11:0];
                    mem_wdata = s_tdata[19:12];
                    mem_we    = s_acc && (s_tuser == OP_WRITE);
                end
                S_FETCH_HI: mem_addr = pc_reg;
                S_FETCH_LO: mem_addr = pc_reg + 12'd1;
                S_STORE:    mem_we   = 1'b1;
                S_BCD: begin
                    mem_we    = 1'b1;
                    mem_wdata = (cnt_reg == 4'd0) ? bcd_h :
                                (cnt_reg == 4'd1) ? bcd_t : bcd_o;
                end
                default: mem_addr = ioff;
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        v_next        = v_reg;
        stack_next    = stack_reg;
        sp_next       = sp_reg;
        i_next        = i_reg;
        pc_next       = pc_reg;
        dt_next       = dt_reg;
        st_next       = st_reg;
        pk_valid_next = pk_valid_reg;
        pk_code_next  = pk_code_reg;
        fb_next       = fb_reg;
        fb_ok_next    = fb_ok_reg;
        keys_next     = keys_reg;
        rnd_next      = rnd_reg;
        op_next       = op_reg;
        ins_next      = ins_reg;
        vx_next       = vx_reg;
        vy_next       = vy_reg;
        cnt_next      = cnt_reg;
        flag_next     = flag_reg;
        status_next   = status_reg;
        chg_next      = chg_reg;
        row_next      = row_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    op_next     = s_tuser;
                    keys_next   = s_tdata[35:20];
                    rnd_next    = s_tdata[48:41];
                    status_next = ST_DONE;
                    chg_next    = 1'b0;
                    row_next    = 64'd0;
                    if (s_tdata[36]) begin
                        pk_valid_next = 1'b1;
                        pk_code_next  = s_tdata[40:37];
                    end
                    if (s_tuser == OP_READ && fb_ok_reg[s_tdata[4:0]]) begin
                        row_next = fb_reg[s_tdata[4:0]];
                    end
                    state_next = (s_tuser == OP_EXEC) ? S_FETCH_HI : S_DONE;
                end
            end
            S_FETCH_HI: state_next = S_FETCH_LO;
            S_FETCH_LO: begin
                ins_next[15:8] = mem_rdata;
                state_next     = S_READ_X;
            end
            S_READ_X: begin
                ins_next[7:0] = mem_rdata;
                vx_next       = v_reg[ins_reg[11:8]];
                state_next    = S_READ_Y;
            end
            S_READ_Y: begin
                vy_next    = v_reg[ins_reg[7:4]];
                state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_DONE;
                cnt_next   = 4'd0;
                flag_next  = 1'b0;
                if (!known_op(ins_reg)) begin
                    status_next = ST_UNKNOWN;
                end else begin
                    dt_next = dt_dec;
                    st_next = st_dec;
                    pc_next = pc2;
                    unique case (ins_reg[15:12])
                        4'h0: begin
                            if (nn == 8'hE0) begin
                                fb_ok_next = '0;
                                chg_next   = 1'b1;
                            end else begin
                                sp_next = sp_dec;
                                pc_next = stack_reg[sp_dec];
                            end
                        end
                        4'h1: pc_next = nnn;
                        4'h2: begin
                            stack_next[sp_reg] = pc2;
                            sp_next            = sp_inc;
                            pc_next            = nnn;
                        end
                        4'h3: pc_next = (vx_reg == nn) ? pc4 : pc2;
                        4'h4: pc_next = (vx_reg != nn) ? pc4 : pc2;
                        4'h5: pc_next = (vx_reg == vy_reg) ? pc4 : pc2;
                        4'h6: v_next[xi] = nn;
                        4'h7: v_next[xi] = alu_y;
                        4'h8: begin
                            v_next[xi] = alu_y;
                            if (nib >= 4'h4) begin
                                v_next[15] = {7'd0, alu_flag};
                            end
                        end
                        4'h9: pc_next = (vx_reg != vy_reg) ? pc4 : pc2;
                        4'hA: i_next = {4'd0, nnn};
                        4'hB: pc_next = nnn + {4'd0, v_reg[0]};
                        4'hC: v_next[xi] = alu_y;
                        4'hD: begin
                            chg_next = 1'b1;
                            if (nib == 4'd0) begin
                                v_next[15] = 8'd0;
                            end else begin
                                state_next = S_DRAW_RD;
                            end
                        end
                        4'hE: begin
                            pc_next = ((nn == 8'h9E) == keys_reg[vx_reg[3:0]]) ? pc4 : pc2;
                        end
                        default: begin
                            case (nn)
                                8'h07: v_next[xi] = dt_dec;
                                8'h0A: begin
                                    if (!pk_valid_reg) begin
                                        pc_next     = pc_reg;
                                        status_next = ST_WAITKEY;
                                    end else begin
                                        v_next[xi]    = {4'd0, pk_code_reg};
                                        pk_valid_next = 1'b0;
                                    end
                                end
                                8'h15: dt_next = vx_reg;
                                8'h18: st_next = vx_reg;
                                8'h1E: i_next = i_reg + {8'd0, vx_reg};
                                8'h29: i_next = {10'd0, vx_reg[3:0], 2'd0} +
                                                {12'd0, vx_reg[3:0]};
                                8'h33: state_next = S_BCD;
                                8'h55: state_next = S_STORE;
                                default: state_next = S_LOAD_RD;
                            endcase
                        end
                    endcase
                end
            end
            S_DRAW_RD: state_next = S_DRAW_WR;
            S_DRAW_WR: begin
                if (!draw_row[8] && !draw_row[7] && !draw_row[6] && !draw_row[5] &&
                    !vx_reg[7] && !vx_reg[6]) begin
                    fb_next[draw_row[4:0]]    = draw_old ^ draw_bits;
                    fb_ok_next[draw_row[4:0]] = 1'b1;
                    if ((draw_old & draw_bits) != 64'd0) begin
                        flag_next = 1'b1;
                    end
                end
                if (cnt_reg == nib - 4'd1) begin
                    v_next[15] = {7'd0, flag_next};
                    state_next = S_DONE;
                end else begin
                    cnt_next   = cnt_reg + 4'd1;
                    state_next = S_DRAW_RD;
                end
            end
            S_STORE: begin
                cnt_next   = cnt_reg + 4'd1;
                state_next = (cnt_reg == xi) ? S_DONE : S_STORE;
            end
            S_LOAD_RD: state_next = S_LOAD_WR;
            S_LOAD_WR: begin
                v_next[cnt_reg] = mem_rdata;
                cnt_next        = cnt_reg + 4'd1;
                state_next      = (cnt_reg == xi) ? S_DONE : S_LOAD_RD;
            end
            S_BCD: begin
                cnt_next   = cnt_reg + 4'd1;
                state_next = (cnt_reg == 4'd2) ? S_DONE : S_BCD;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            sp_reg       <= '0;
            i_reg        <= 16'd0;
            pc_reg       <= PC_START;
            dt_reg       <= 8'd0;
            st_reg       <= 8'd0;
            pk_valid_reg <= 1'b0;
            pk_code_reg  <= 4'd0;
            fb_ok_reg    <= '0;
            clr_reg      <= 1'b1;
            clr_cnt_reg  <= 12'd0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < 16; k++) begin
                v_reg[k] <= 8'd0;
            end
        end else begin
            state_reg    <= state_next;
            sp_reg       <= sp_next;
            i_reg        <= i_next;
            pc_reg       <= pc_next;
            dt_reg       <= dt_next;
            st_reg       <= st_next;
            pk_valid_reg <= pk_valid_next;
            pk_code_reg  <= pk_code_next;
            fb_ok_reg    <= fb_ok_next;
            v_reg        <= v_next;
            if (clr_reg) begin
                clr_cnt_reg <= clr_cnt_reg + 12'd1;
                if (clr_cnt_reg == 12'(MEM_BYTES - 1)) begin
                    clr_reg <= 1'b0;
                end
            end
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        stack_reg  <= stack_next;
        fb_reg     <= fb_next;
        keys_reg   <= keys_next;
        rnd_reg    <= rnd_next;
        op_reg     <= op_next;
        ins_reg    <= ins_next;
        vx_reg     <= vx_next;
        vy_reg     <= vy_next;
        cnt_reg    <= cnt_next;
        flag_reg   <= flag_next;
        status_reg <= status_next;
        chg_reg    <= chg_next;
        row_reg    <= row_next;
        if (state_reg == S_DONE && out_free) begin
            m_user_reg <= (op_reg == OP_EXEC) ? status_reg : ST_DONE;
            m_data_reg <= {2'd0, row_reg, chg_reg, (st_reg != 8'd0), pc_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
endmodule

### design/c8_ram.sv
module c8_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

### design/c8_alu.sv
module c8_alu
    import c8_pkg::*;
(
    input  alu_op_t    sel,
    input  logic [7:0] a,
    input  logic [7:0] b,
    output logic [7:0] y,
    output logic       flag
);
    logic [8:0] sum;

    assign sum = {1'b0, a} + {1'b0, b};

    always_comb begin
        y    = b;
        flag = 1'b0;
        case (sel)
            ALU_PASS: y = b;
            ALU_OR:   y = a | b;
            ALU_AND:  y = a & b;
            ALU_XOR:  y = a ^ b;
            ALU_ADD: begin
                y    = sum[7:0];
                flag = sum[8];
            end
            ALU_SUB: begin
                y    = a - b;
                flag = (a >= b);
            end
            ALU_SHR: begin
                y    = {1'b0, a[7:1]};
                flag = a[0];
            end
            ALU_SHL: begin
                y    = {a[6:0], 1'b0};
                flag = a[7];
            end
            default: y = b;
        endcase
    end
endmodule
